/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the deque RTL. Empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset
`define DQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("deque assertion failed");

// Check that a condition never holds outside reset
`define DQ_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("deque assertion failed");

`else

`define DQ_ASSERT(name, clk, rst_n, prop)
`define DQ_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

/* rtl/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, codes and control types of the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Ring geometry
  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } dq_op_e;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_OUT
  } dq_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture the incoming beat
    logic exec;     // apply the operation to the ring
    logic take_rd;  // capture the word read from the ring
  } dq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mem_read; // the operation reads a stored word
  } dq_sts_t;

endpackage

/* rtl/dq_ram.sv */
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer of the deque: takes one beat, runs it through the ring and
// presents the result until the consumer takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_ctrl
  import dq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dq_cmd_t cmd_o,
  input  dq_sts_t sts_i
);

  dq_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.mem_read ? S_READ : S_OUT;
      end
      S_READ: begin
        cmd_o.take_rd = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // A read of the ring always passes through S_READ to wait for the RAM
  `DQ_ASSERT(a_read_wait, clk_i, rst_ni, (state_q == S_EXEC && sts_i.mem_read) |=> (state_q == S_READ))
  // No second beat is taken while one is in flight
  `DQ_ASSERT(a_one_item, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // Once the result beat leaves, the input opens again
  `DQ_ASSERT(a_reopen, clk_i, rst_ni, (out_valid_o && !out_stall_i) |=> !in_stall_o)

endmodule

/* rtl/dq_dp.sv */
// ----------------------------------------------------------------------------
// dq_dp
// Datapath of the deque: head index, word count, ring storage and the
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_dp
  import dq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dq_cmd_t                  cmd_i,
  output dq_sts_t                  sts_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic signed [WORD_W-1:0] data_value_i,
  output logic signed [WORD_W-1:0] read_value_o,
  output logic [ST_W-1:0]          status_o,
  output logic [CNT_W-1:0]         entry_count_o,
  output logic                     is_empty_o
);

  localparam int SUM_W = IDX_W + 2;

  dq_op_e              op_q;
  logic [WORD_W-1:0]   data_q;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [WORD_W-1:0]   rd_q, rd_d;
  dq_status_e          st_q, st_d;

  logic                full, empty, push;
  logic [IDX_W-1:0]    head_inc, head_dec, tail_slot, back_slot;
  logic [SUM_W-1:0]    end_sum;
  logic                we, re;
  logic [IDX_W-1:0]    waddr, raddr;
  logic [WORD_W-1:0]   ram_rdata;

  // Fold a sum below twice the depth back into the ring
  function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] x);
    logic [SUM_W-1:0] r;
    r = (x >= SUM_W'(DEPTH)) ? (x - SUM_W'(DEPTH)) : x;
    return r[IDX_W-1:0];
  endfunction

  // Capture the incoming beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= dq_op_e'(opcode_i);
      data_q <= data_value_i;
    end
  end

  // Ring positions
  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign head_inc  = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
  assign head_dec  = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);
  assign end_sum   = SUM_W'(head_q) + SUM_W'(count_q);
  assign tail_slot = wrap(end_sum);
  assign back_slot = wrap(end_sum - SUM_W'(1));
  assign push      = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK);

  // Decode the operation
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    rd_d    = '0;
    st_d    = ST_OK;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = head_dec;
    raddr   = head_q;
    case (op_q)
      OP_PUSH_FRONT: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          we      = 1'b1;
          waddr   = head_dec;
          head_d  = head_dec;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          we      = 1'b1;
          waddr   = tail_slot;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (empty) begin
          rd_d = '1;
          st_d = ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = head_q;
          if (op_q == OP_POP_FRONT) begin
            head_d  = head_inc;
            count_d = count_q - CNT_W'(1);
          end
        end
      end
      OP_POP_BACK, OP_PEEK_BACK: begin
        if (empty) begin
          rd_d = '1;
          st_d = ST_EMPTY;
        end else begin
          re    = 1'b1;
          raddr = back_slot;
          if (op_q == OP_POP_BACK) begin
            count_d = count_q - CNT_W'(1);
          end
        end
      end
      default: begin
        st_d = ST_OK;
      end
    endcase
  end

  // Advance the ring pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Hold the result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rd_q <= rd_d;
      st_q <= st_d;
    end else if (cmd_i.take_rd) begin
      rd_q <= ram_rdata;
    end
  end

  // Ring storage
  dq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && we),
    .waddr_i (waddr),
    .wdata_i (data_q),
    .re_i    (cmd_i.exec && re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.mem_read = re;

  assign read_value_o  = rd_q;
  assign status_o      = st_q;
  assign entry_count_o = count_q;
  assign is_empty_o    = empty;

  // The count never passes the ring size
  `DQ_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, count_q > CNT_W'(DEPTH))
  // The head always points inside the ring
  `DQ_ASSERT_NEVER(a_head_bound, clk_i, rst_ni, head_q > IDX_W'(DEPTH - 1))
  // A rejected push leaves the count alone
  `DQ_ASSERT(a_full_hold, clk_i, rst_ni, (cmd_i.exec && push && full) |=> $stable(count_q))

endmodule

/* rtl/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit words in a ring of DEPTH entries:
// push, pop or peek at either end, one result beat per operation.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | consumer  | in_valid_i / in_stall_o | opcode_i, data_value_i
//  out     | producer  | out_valid_o/out_stall_i | read_value_o, status_o,
//          |           |                         | entry_count_o, is_empty_o
//
//  A beat passes capture, execute and present before the input is free again,
//  plus a read step when a stored word is popped or peeked: the ring RAM
//  has a registered read port. An output stall holds the present step.
//  Reset empties the queue (head and count to zero); RAM contents are kept.
//  The input stalls while a beat is in flight or its result waits.
// ----------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic signed [WORD_W-1:0] data_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [WORD_W-1:0] read_value_o,
  output logic [ST_W-1:0]          status_o,
  output logic [CNT_W-1:0]         entry_count_o,
  output logic                     is_empty_o
);

  dq_cmd_t cmd;
  dq_sts_t sts;

  // Sequencer
  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Ring and result datapath
  dq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .data_value_i  (data_value_i),
    .read_value_o  (read_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o)
  );

endmodule

/* tb/double_ended_queue_test.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Self-checking bench for the ring-buffer deque. A short table of directed
// operations covers the empty and full cases, the unused opcodes and the
// word extremes. Random traffic follows in runs that lean toward filling or
// draining the ring or take any opcode. Every result beat is checked against
// the table's result on typed rows, else against a shadow ring in the bench.
// Gaps and stalls are random on both channels, plus one long output hold.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
  import dq_pkg::*;

  // Opcodes that the block ignores
  localparam logic [OP_W-1:0] OP_NOP_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_NOP_HI = 3'd7;

  localparam int QUEUE_OPS   = 1800;
  localparam int QUIET_FROM  = 1600;
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    dq_status_e               st;
    logic [CNT_W-1:0]         cnt;
    logic                     empty;
  } dq_answer_t;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [WORD_W-1:0] word;
    int                       reps;
    bit                       typed;
    logic signed [WORD_W-1:0] x_word;
    dq_status_e               x_st;
    int                       x_cnt;
    bit                       x_empty;
  } plan_row_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [OP_W-1:0]          opcode_i;
  logic signed [WORD_W-1:0] data_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [WORD_W-1:0] read_value_o;
  logic [ST_W-1:0]          status_o;
  logic [CNT_W-1:0]         entry_count_o;
  logic                     is_empty_o;

  // Shadow copy of the ring
  logic signed [WORD_W-1:0] shadow_ring [DEPTH];
  int                       shadow_head;
  int                       shadow_count;

  dq_answer_t pending_answers [$];

  int n_errors;
  int n_beats;
  int n_refused;
  int n_empty_reads;
  int peak_count;
  bit quiet;
  bit hold_req;

  // Directed operations; typed rows carry the result that follows at a glance
  plan_row_t plan [17] = '{
    '{OP_POP_FRONT,  32'sd0,            1, 1, -32'sd1, ST_EMPTY, 0,  1},
    '{OP_POP_BACK,   32'sd0,            1, 1, -32'sd1, ST_EMPTY, 0,  1},
    '{OP_PEEK_FRONT, 32'sd0,            1, 1, -32'sd1, ST_EMPTY, 0,  1},
    '{OP_PEEK_BACK,  32'sd0,            1, 1, -32'sd1, ST_EMPTY, 0,  1},
    '{OP_NOP_LO,     32'sh1234_5678,    1, 1, 32'sd0,  ST_OK,    0,  1},
    '{OP_PUSH_BACK,  32'sh7FFF_FFFF,    1, 1, 32'sd0,  ST_OK,    1,  0},
    '{OP_PUSH_FRONT, 32'sh8000_0000,    1, 1, 32'sd0,  ST_OK,    2,  0},
    '{OP_PUSH_BACK,  -32'sd1,           1, 1, 32'sd0,  ST_OK,    3,  0},
    '{OP_PUSH_FRONT, 32'sd0,            1, 1, 32'sd0,  ST_OK,    4,  0},
    '{OP_PEEK_FRONT, 32'sd0,            1, 0, 32'sd0,  ST_OK,    0,  0},
    '{OP_PEEK_BACK,  32'sd0,            1, 0, 32'sd0,  ST_OK,    0,  0},
    '{OP_PUSH_FRONT, 32'sh0000_1000,    6, 0, 32'sd0,  ST_OK,    0,  0},
    '{OP_PUSH_BACK,  32'sh0000_2000,    6, 0, 32'sd0,  ST_OK,    0,  0},
    '{OP_PUSH_FRONT, 32'sh5A5A_5A5A,    1, 1, 32'sd0,  ST_FULL,  16, 0},
    '{OP_NOP_HI,     32'shFFFF_0000,    1, 1, 32'sd0,  ST_OK,    16, 0},
    '{OP_POP_FRONT,  32'sd0,            1, 0, 32'sd0,  ST_OK,    0,  0},
    '{OP_POP_BACK,   32'sd0,            1, 0, 32'sd0,  ST_OK,    0,  0}
  };

  double_ended_queue i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .data_value_i (data_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one operation to the shadow ring and return its result beat
  function automatic dq_answer_t deque_apply(logic [OP_W-1:0] op,
                                             logic signed [WORD_W-1:0] word);
    dq_answer_t ans;
    ans.word = '0;
    ans.st   = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          ans.st = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_head] = word;
          shadow_count++;
        end else begin
          shadow_ring[(shadow_head + shadow_count) % DEPTH] = word;
          shadow_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (shadow_count == 0) begin
          ans.word = -32'sd1;
          ans.st   = ST_EMPTY;
        end else if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) begin
          ans.word = shadow_ring[shadow_head];
          if (op == OP_POP_FRONT) begin
            shadow_head = (shadow_head + 1) % DEPTH;
            shadow_count--;
          end
        end else begin
          ans.word = shadow_ring[(shadow_head + shadow_count - 1) % DEPTH];
          if (op == OP_POP_BACK) begin
            shadow_count--;
          end
        end
      end
      default: begin
        // unused opcode: state untouched
      end
    endcase
    ans.cnt   = CNT_W'(shadow_count);
    ans.empty = (shadow_count == 0);
    return ans;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    n_errors++;
    $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // Offer one beat, hold it until taken, then record its result
  task automatic offer_beat(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] word,
                            bit typed, dq_answer_t typed_ans);
    dq_answer_t ans;
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    data_value_i <= word;
    do @(posedge clk_i); while (in_stall_o);
    ans = deque_apply(op, word);
    if (typed) begin
      ans = typed_ans;
    end
    pending_answers.push_back(ans);
    n_beats++;
    if (ans.st == ST_FULL) n_refused++;
    if (ans.st == ST_EMPTY) n_empty_reads++;
    if (ans.cnt > peak_count) peak_count = ans.cnt;
    // Drop valid for a short burst now and then
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_read();
    case ($urandom_range(0, 5))
      0, 1:    return OP_POP_FRONT;
      2, 3:    return OP_POP_BACK;
      4:       return OP_PEEK_FRONT;
      default: return OP_PEEK_BACK;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    if (mix == MIX_ANY) return OP_W'($urandom_range(0, 7));
    if (r < ((mix == MIX_FILL) ? 70 : 25)) begin
      return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    end
    if (r < 97) return pick_read();
    return $urandom_range(0, 1) ? OP_NOP_HI : OP_NOP_LO;
  endfunction

  // Stimulus: reset, directed table, random traffic, drain
  initial begin
    dq_answer_t       typed_ans;
    logic [OP_W-1:0]  op;
    mix_e             mix;
    int               run_left;
    int               n_ops;
    bit               hold_issued;
    in_valid_i   = 1'b0;
    opcode_i     = '0;
    data_value_i = '0;
    n_errors = 0;
    n_beats = 0;
    n_refused = 0;
    n_empty_reads = 0;
    peak_count = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    shadow_head = 0;
    shadow_count = 0;
    n_ops = 0;
    hold_issued = 1'b0;
    run_left = 0;
    mix = MIX_FILL;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (plan[i]) begin
      typed_ans.word  = plan[i].x_word;
      typed_ans.st    = plan[i].x_st;
      typed_ans.cnt   = CNT_W'(plan[i].x_cnt);
      typed_ans.empty = plan[i].x_empty;
      for (int k = 0; k < plan[i].reps; k++) begin
        offer_beat(plan[i].op, plan[i].word + k, plan[i].typed, typed_ans);
      end
    end

    // Random traffic in runs that lean toward filling or draining, or take any opcode
    while (n_ops < QUEUE_OPS) begin
      if (run_left == 0) begin
        mix = mix_e'($urandom_range(0, 2));
        run_left = $urandom_range(20, 60);
      end
      run_left--;
      if (n_ops >= QUIET_FROM) quiet = 1'b1;
      if (n_ops >= HOLD_AT && !hold_issued) begin
        hold_req = 1'b1;
        hold_issued = 1'b1;
      end
      op = pick_op(mix);
      n_ops++;
      offer_beat(op, pick_word(), 1'b0, typed_ans);
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding results, then let the pipeline settle
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d operations: %0d pushes refused on a full ring, %0d empty reads",
             n_beats, n_refused, n_empty_reads);
    $display("peak occupancy %0d of %0d, one output hold of %0d cycles",
             peak_count, DEPTH, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("double_ended_queue_test: clean");
    end else begin
      $display("double_ended_queue_test: errors");
    end
    $finish;
  end

  // Receiver: random stall bursts, one long hold on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each taken result beat with the oldest pending answer
  always @(posedge clk_i) begin : check_results
    dq_answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("beat with no operation pending", read_value_o, '0);
      end else begin
        want = pending_answers.pop_front();
        if (read_value_o !== want.word) begin
          report_mismatch("read_value", read_value_o, want.word);
        end
        if (status_o !== want.st) begin
          report_mismatch("status", WORD_W'(status_o), WORD_W'(want.st));
        end
        if (entry_count_o !== want.cnt) begin
          report_mismatch("entry_count", WORD_W'(entry_count_o), WORD_W'(want.cnt));
        end
        if (is_empty_o !== want.empty) begin
          report_mismatch("is_empty", WORD_W'(is_empty_o), WORD_W'(want.empty));
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("double_ended_queue_test: errors");
    $finish;
  end

endmodule
